>>> hw/rtl/vran_pkg.sv
// shared constants, types and helpers of the vector reflection datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vran_pkg;

  localparam int CW     = 24;          // component width, signed fixed point
  localparam int CFG_W  = 16;          // threshold register width
  localparam int PROD_W = 2 * CW;      // products, squared length, dot product
  localparam int NUM_W  = 3 * CW;      // 2 * |dot| * |n_c|
  localparam int QB     = CW + 2;      // quotient bits, one per divider stage
  localparam int RW     = NUM_W + 2;   // trial divisor width
  localparam int RSW    = QB + 2;      // signed sum before clamping

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(43);

  localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic [2:0][CW-1:0] vec_t;

  // per-item side data that rides along the divider
  typedef struct packed {
    logic       degen;
    logic [2:0] qneg;
    vec_t       inc;
  } tag_t;

  typedef struct packed {
    tag_t                       tag;
    logic [PROD_W-1:0]          dsr;
    logic [2:0][NUM_W-1:0]      num;
  } div_in_t;

  typedef struct packed {
    tag_t                       tag;
    logic [PROD_W-1:0]          dsr;
    logic [2:0][PROD_W-1:0]     rem;
    logic [2:0][QB-1:0]         quo;
  } div_out_t;

  typedef struct packed {
    vec_t refl;
    logic degen;
    logic sat;
  } result_t;

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vran_in_if.sv
// input channel: incident vector and surface normal with valid/ready
// depends on vran_pkg
`timescale 1ns / 1ps
`default_nettype none

interface vran_in_if;
  import vran_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] incident_x;
  logic signed [CW-1:0] incident_y;
  logic signed [CW-1:0] incident_z;
  logic signed [CW-1:0] normal_x;
  logic signed [CW-1:0] normal_y;
  logic signed [CW-1:0] normal_z;

  modport source (output valid, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vran_out_if.sv
// output channel: reflected vector and status flags with valid/ready
// depends on vran_pkg
`timescale 1ns / 1ps
`default_nettype none

interface vran_out_if;
  import vran_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] reflected_x;
  logic signed [CW-1:0] reflected_y;
  logic signed [CW-1:0] reflected_z;
  logic                 degenerate_normal;
  logic                 saturated;

  modport source (output valid, reflected_x, reflected_y, reflected_z,
                  degenerate_normal, saturated, input ready);
  modport sink   (input valid, reflected_x, reflected_y, reflected_z,
                  degenerate_normal, saturated, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vran_front.sv
// front stages: products, sums, dot sign and magnitude, numerator build
// depends on vran_pkg
`timescale 1ns / 1ps
`default_nettype none

module vran_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire logic                     valid_i,
  input  wire vran_pkg::vec_t           inc_i,
  input  wire vran_pkg::vec_t           nrm_i,
  input  wire logic [vran_pkg::CFG_W-1:0] min_len_i,
  output logic                          valid_o,
  output vran_pkg::div_in_t             div_o
);
  import vran_pkg::*;

  // stage 1: magnitude products
  logic                   s1_valid_q;
  vec_t                   s1_inc_q, s1_nmag_q;
  logic [2:0]             s1_nneg_q, s1_psgn_q;
  logic [2:0][PROD_W-1:0] s1_prod_q, s1_nsq_q, s1_prod_d, s1_nsq_d;
  vec_t                   s1_nmag_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s1_nmag_d[c] = mag(nrm_i[c]);
      s1_prod_d[c] = PROD_W'(mag(inc_i[c])) * PROD_W'(s1_nmag_d[c]);
      s1_nsq_d[c]  = PROD_W'(s1_nmag_d[c]) * PROD_W'(s1_nmag_d[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_inc_q  <= inc_i;
      s1_nmag_q <= s1_nmag_d;
      s1_prod_q <= s1_prod_d;
      s1_nsq_q  <= s1_nsq_d;
      for (int c = 0; c < 3; c++) begin
        s1_nneg_q[c] <= nrm_i[c][CW-1];
        s1_psgn_q[c] <= inc_i[c][CW-1] ^ nrm_i[c][CW-1];
      end
    end
  end

  // stage 2: squared length and signed partial sums
  logic              s2_valid_q;
  vec_t              s2_inc_q, s2_nmag_q;
  logic [2:0]        s2_nneg_q;
  logic [PROD_W-1:0] s2_len_q, s2_pos_q, s2_neg_q, s2_pos_d, s2_neg_d;

  always_comb begin
    s2_pos_d = '0;
    s2_neg_d = '0;
    for (int c = 0; c < 3; c++) begin
      if (s1_psgn_q[c]) s2_neg_d = s2_neg_d + s1_prod_q[c];
      else              s2_pos_d = s2_pos_d + s1_prod_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_inc_q  <= s1_inc_q;
      s2_nmag_q <= s1_nmag_q;
      s2_nneg_q <= s1_nneg_q;
      s2_len_q  <= s1_nsq_q[0] + s1_nsq_q[1] + s1_nsq_q[2];
      s2_pos_q  <= s2_pos_d;
      s2_neg_q  <= s2_neg_d;
    end
  end

  // stage 3: dot magnitude, sign and degenerate test
  logic              s3_valid_q;
  vec_t              s3_nmag_q;
  tag_t              s3_tag_q;
  logic [PROD_W-1:0] s3_len_q, s3_dmag_q;
  logic              s3_dneg;

  assign s3_dneg = s2_neg_q > s2_pos_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_nmag_q      <= s2_nmag_q;
      s3_len_q       <= s2_len_q;
      s3_dmag_q      <= s3_dneg ? (s2_neg_q - s2_pos_q) : (s2_pos_q - s2_neg_q);
      s3_tag_q.inc   <= s2_inc_q;
      s3_tag_q.degen <= (s2_len_q == '0) || (s2_len_q < PROD_W'(min_len_i));
      s3_tag_q.qneg  <= {3{s3_dneg}} ^ s2_nneg_q;
    end
  end

  // stage 4: split multiply of dot magnitude by twice the normal component
  logic                     s4_valid_q;
  tag_t                     s4_tag_q;
  logic [PROD_W-1:0]        s4_len_q;
  logic [2:0][2*CW:0]       s4_plo_q, s4_phi_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_tag_q <= s3_tag_q;
      s4_len_q <= s3_len_q;
      for (int c = 0; c < 3; c++) begin
        s4_plo_q[c] <= (2*CW+1)'(s3_dmag_q[CW-1:0]) * (2*CW+1)'({s3_nmag_q[c], 1'b0});
        s4_phi_q[c] <= (2*CW+1)'(s3_dmag_q[PROD_W-1:CW]) * (2*CW+1)'({s3_nmag_q[c], 1'b0});
      end
    end
  end

  // stage 5: combine partials into the numerator
  logic    s5_valid_q;
  div_in_t s5_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_q.tag <= s4_tag_q;
      s5_q.dsr <= s4_len_q;
      for (int c = 0; c < 3; c++) begin
        s5_q.num[c] <= NUM_W'({s4_phi_q[c], {CW{1'b0}}}) + NUM_W'(s4_plo_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  assign valid_o = s5_valid_q;
  assign div_o   = s5_q;

endmodule

`default_nettype wire

>>> hw/rtl/vran_divider.sv
// pipelined restoring divider, one quotient bit per stage, three lanes
// depends on vran_pkg
`timescale 1ns / 1ps
`default_nettype none

module vran_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire vran_pkg::div_in_t div_i,
  output logic                   valid_o,
  output vran_pkg::div_out_t     div_o
);
  import vran_pkg::*;

  typedef struct packed {
    tag_t                  tag;
    logic [PROD_W-1:0]     dsr;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QB-1:0]    quo;
  } step_t;

  step_t          st_q [QB];
  logic [QB-1:0]  vld_q;

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    step_t          prev, nxt;
    logic           prev_vld;
    logic [RW-1:0]  trial;

    if (j == 0) begin : g_first
      assign prev.tag = div_i.tag;
      assign prev.dsr = div_i.dsr;
      assign prev.rem = div_i.num;
      assign prev.quo = '0;
      assign prev_vld = valid_i;
    end else begin : g_next
      assign prev     = st_q[j-1];
      assign prev_vld = vld_q[j-1];
    end

    assign trial = RW'(prev.dsr) << K;

    always_comb begin
      nxt = prev;
      for (int c = 0; c < 3; c++) begin
        if (RW'(prev.rem[c]) >= trial) begin
          nxt.rem[c]    = prev.rem[c] - NUM_W'(trial);
          nxt.quo[c][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) st_q[j] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv_i) begin
        vld_q[j] <= prev_vld;
      end
    end
  end

  // final remainder is below the divisor, so its low PROD_W bits suffice
  always_comb begin
    div_o.tag = st_q[QB-1].tag;
    div_o.dsr = st_q[QB-1].dsr;
    div_o.quo = st_q[QB-1].quo;
    for (int c = 0; c < 3; c++) begin
      div_o.rem[c] = st_q[QB-1].rem[c][PROD_W-1:0];
    end
  end

  assign valid_o = vld_q[QB-1];

endmodule

`default_nettype wire

>>> hw/rtl/vran_back.sv
// back stages: round the quotient, apply it to the incident vector, clamp
// depends on vran_pkg
`timescale 1ns / 1ps
`default_nettype none

module vran_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire vran_pkg::div_out_t div_i,
  output logic                    valid_o,
  output vran_pkg::result_t       res_o
);
  import vran_pkg::*;

  // stage 1: round to nearest, ties away from zero
  logic               r1_valid_q;
  tag_t               r1_tag_q;
  logic [2:0][QB-1:0] r1_quo_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r1_tag_q <= div_i.tag;
      for (int c = 0; c < 3; c++) begin
        r1_quo_q[c] <= div_i.quo[c]
          + QB'({div_i.rem[c], 1'b0} >= {1'b0, div_i.dsr});
      end
    end
  end

  // stage 2: add or subtract, saturate, pick pass-through for short normals
  logic                     r2_valid_q;
  result_t                  r2_q, r2_d;
  logic signed [RSW-1:0]    sum;
  logic [RSW-1:0]           iext, qext;
  logic [RSW-CW:0]          top;

  always_comb begin
    r2_d.sat   = 1'b0;
    r2_d.degen = r1_tag_q.degen;
    sum        = '0;
    iext       = '0;
    qext       = '0;
    top        = '0;
    for (int c = 0; c < 3; c++) begin
      iext = {{(RSW-CW){r1_tag_q.inc[c][CW-1]}}, r1_tag_q.inc[c]};
      qext = {{(RSW-QB){1'b0}}, r1_quo_q[c]};
      sum  = r1_tag_q.qneg[c] ? $signed(iext + qext) : $signed(iext - qext);
      top  = sum[RSW-1:CW-1];
      if (r1_tag_q.degen) begin
        r2_d.refl[c] = r1_tag_q.inc[c];
      end else if ((top != '0) && (top != '1)) begin
        r2_d.refl[c] = sum[RSW-1] ? COMP_MIN : COMP_MAX;
        r2_d.sat     = 1'b1;
      end else begin
        r2_d.refl[c] = sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) r2_q <= r2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
    end else if (adv_i) begin
      r1_valid_q <= valid_i;
      r2_valid_q <= r1_valid_q;
    end
  end

  assign valid_o = r2_valid_q;
  assign res_o   = r2_q;

endmodule

`default_nettype wire

>>> hw/rtl/vector_reflect_about_normal.sv
// an accepted input beat passes 5 front, 26 divider and 2 back stages on its way
// to its result beat, one beat per cycle sustained while the sink takes results
// the 26-stage restoring divider, one quotient bit per stage, sets the latency
// a result beat that is not taken parks in a skid register; the pipeline holds
// reset clears all valid bits including the skid valid bit, threshold resets to 43
`timescale 1ns / 1ps
`default_nettype none

module vector_reflect_about_normal (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [vran_pkg::CFG_W-1:0]  cfg_wdata_i,
  vran_in_if.sink                          in_i,
  vran_out_if.source                       out_o
);
  import vran_pkg::*;

  logic [CFG_W-1:0] min_len_q;
  logic             adv;
  vec_t             inc, nrm;
  logic             front_valid, div_valid, back_valid;
  div_in_t          front_div;
  div_out_t         div_out;
  result_t          back_res, skid_q, res;
  logic             skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  assign adv      = !skid_v_q;
  assign in_i.ready = adv;

  assign inc[0] = in_i.incident_x;
  assign inc[1] = in_i.incident_y;
  assign inc[2] = in_i.incident_z;
  assign nrm[0] = in_i.normal_x;
  assign nrm[1] = in_i.normal_y;
  assign nrm[2] = in_i.normal_z;

  vran_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (in_i.valid),
    .inc_i     (inc),
    .nrm_i     (nrm),
    .min_len_i (min_len_q),
    .valid_o   (front_valid),
    .div_o     (front_div)
  );

  vran_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .div_i   (front_div),
    .valid_o (div_valid),
    .div_o   (div_out)
  );

  vran_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid),
    .div_i   (div_out),
    .valid_o (back_valid),
    .res_o   (back_res)
  );

  // skid register catches the last stage when the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) skid_v_q <= 1'b0;
    end else if (back_valid && !out_o.ready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) skid_q <= back_res;
  end

  assign res = skid_v_q ? skid_q : back_res;

  assign out_o.valid             = skid_v_q | back_valid;
  assign out_o.reflected_x       = res.refl[0];
  assign out_o.reflected_y       = res.refl[1];
  assign out_o.reflected_z       = res.refl[2];
  assign out_o.degenerate_normal = res.degen;
  assign out_o.saturated         = res.sat;

`ifndef NO_ASSERTIONS
  a_degen_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate_normal) |-> !out_o.saturated)
    else $error("degenerate beat flagged as saturated");

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.reflected_x == COMP_MAX || out_o.reflected_x == COMP_MIN ||
       out_o.reflected_y == COMP_MAX || out_o.reflected_y == COMP_MIN ||
       out_o.reflected_z == COMP_MAX || out_o.reflected_z == COMP_MIN))
    else $error("saturated beat has no component at a rail");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_o.ready) |=> (skid_v_q && $stable(skid_q)))
    else $error("skid register lost or changed a parked beat");
`endif

endmodule

`default_nettype wire
